>>> src/mfde_pkg.sv
package mfde_pkg;

	localparam int DEF_WIDTH         = 256;
	localparam int DEF_HEIGHT        = 128;
	localparam int DEF_BYTES_PER_ROW = 32;

	localparam int STORE_DEPTH = 4096;
	localparam int ADDR_W      = 12;

	localparam logic [7:0] TOP_BIT   = 8'h80;
	localparam logic [7:0] FULL_MASK = 8'hFF;

	localparam logic [2:0] FN_SET   = 3'd0;
	localparam logic [2:0] FN_GET   = 3'd1;
	localparam logic [2:0] FN_HLINE = 3'd2;
	localparam logic [2:0] FN_VLINE = 3'd3;
	localparam logic [2:0] FN_RECT  = 3'd4;
	localparam logic [2:0] FN_INV   = 3'd5;

	localparam logic [1:0] OP_SET  = 2'd0;
	localparam logic [1:0] OP_CLR  = 2'd1;
	localparam logic [1:0] OP_XOR  = 2'd2;
	localparam logic [1:0] OP_READ = 2'd3;

	typedef struct packed {
		logic [2:0]  func;
		logic [15:0] x;
		logic [15:0] y;
		logic [15:0] x_end;
		logic [15:0] y_end;
		logic [15:0] rect_width;
		logic [15:0] rect_height;
		logic        color;
		logic        filled;
		logic [12:0] byte_count;
	} cmd_t;

	typedef struct packed {
		logic       pixel;
		logic [2:0] done_func;
	} result_t;

	typedef struct packed {
		logic              vld;
		logic [1:0]        kind;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        mask;
	} pix_op_t;

	typedef struct packed {
		logic pend;
		logic rd_pix;
	} store_stat_t;

endpackage

>>> src/mfde_store.sv
module mfde_store import mfde_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  pix_op_t     req,
	output store_stat_t stat
);

	logic [7:0]        mem [STORE_DEPTH];
	logic [7:0]        rdata_q;

	logic              vld_s1;
	logic [1:0]        kind_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [7:0]        mask_s1;

	logic              wr_vld_q;
	logic [ADDR_W-1:0] wr_addr_q;
	logic [7:0]        wr_data_q;

	logic [7:0]        old_byte;
	logic [7:0]        new_byte;
	logic              wr_en;

	// forward the byte written last cycle; the read at that edge saw the old value
	always_comb begin
		old_byte = (wr_vld_q && wr_addr_q == addr_s1) ? wr_data_q : rdata_q;
		case (kind_s1)
			OP_SET:  new_byte = old_byte | mask_s1;
			OP_CLR:  new_byte = old_byte & ~mask_s1;
			OP_XOR:  new_byte = old_byte ^ mask_s1;
			default: new_byte = old_byte;
		endcase
		wr_en       = vld_s1 && kind_s1 != OP_READ;
		stat.pend   = vld_s1;
		stat.rd_pix = vld_s1 && kind_s1 == OP_READ && |(old_byte & mask_s1);
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[req.addr];
		if (wr_en) begin
			mem[addr_s1] <= new_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			wr_vld_q <= 1'b0;
		end else begin
			vld_s1    <= req.vld;
			kind_s1   <= req.kind;
			addr_s1   <= req.addr;
			mask_s1   <= req.mask;
			wr_vld_q  <= wr_en;
			wr_addr_q <= addr_s1;
			wr_data_q <= new_byte;
		end
	end

endmodule

>>> src/mono_framebuffer_draw_engine.sv
// Drawing engine over a 4096-byte, 1 bit per pixel framebuffer (MSB first, row-major).
// Command channel: drive cmd and raise start; the item is taken at a rising edge with
// start high and busy low. Result channel: done pulses for one cycle with result
// (pixel read by a get, else 0, and the echoed command code); there is no back-pressure.
// Processing after an item is taken:
//   set / get pixel: one store access unless out of range; unused codes: none.
//   horizontal or vertical line: load and clamp the ends, then one write per drawn pixel.
//   outlined rectangle: four such lines in turn.
//   filled rectangle: every screen row is tested, with a line drawn for each row hit.
//   invert: XOR of bytes from address 0, byte_count of them (clamped to the buffer).
// Every pixel or byte written is a read-modify-write through the store's registered synchronous
// read; back-to-back writes to one byte are forwarded, so the walk issues one per cycle.
// After reset a clearing pass writes zeros to all 4096 bytes, one per cycle; busy stays
// high throughout the pass and no item is taken.
module mono_framebuffer_draw_engine import mfde_pkg::*; #(
	parameter int WIDTH         = DEF_WIDTH,
	parameter int HEIGHT        = DEF_HEIGHT,
	parameter int BYTES_PER_ROW = DEF_BYTES_PER_ROW
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  cmd_t    cmd,
	output logic    done,
	output result_t result
);

	localparam int YW       = (HEIGHT > 1) ? $clog2(HEIGHT) : 1;
	localparam int MAX_ADDR = (HEIGHT - 1) * BYTES_PER_ROW + (WIDTH - 1) / 8;
	localparam int AFW_RAW  = $clog2(MAX_ADDR + 1);
	localparam int AFW      = (AFW_RAW > ADDR_W) ? AFW_RAW : ADDR_W + 1;
	localparam int BUF_RAW  = HEIGHT * BYTES_PER_ROW;
	localparam int BUF_BYTES = (BUF_RAW > STORE_DEPTH) ? STORE_DEPTH : BUF_RAW;

	localparam logic [15:0]       W_LIM    = 16'(WIDTH);
	localparam logic [15:0]       H_LIM    = 16'(HEIGHT);
	localparam logic [15:0]       X_LAST   = 16'(WIDTH - 1);
	localparam logic [15:0]       Y_LAST   = 16'(HEIGHT - 1);
	localparam logic [YW-1:0]     ROW_LAST = YW'(HEIGHT - 1);
	localparam logic [ADDR_W:0]   BUF_N    = (ADDR_W + 1)'(BUF_BYTES);
	localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(STORE_DEPTH - 1);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_SEG   = 3'd2;
	localparam logic [2:0] ST_LINIT = 3'd3;
	localparam logic [2:0] ST_WALK  = 3'd4;
	localparam logic [2:0] ST_ROW   = 3'd5;
	localparam logic [2:0] ST_INV   = 3'd6;
	localparam logic [2:0] ST_FIN   = 3'd7;

	logic [2:0]        state_q;
	cmd_t              cmd_q;
	logic [15:0]       xr_q;
	logic [15:0]       yb_q;
	logic [1:0]        seg_q;
	logic [YW-1:0]     row_q;
	logic [ADDR_W-1:0] inv_q;
	logic [ADDR_W:0]   inv_n_q;
	logic [ADDR_W-1:0] clr_q;
	logic              horiz_q;
	logic [15:0]       fix_q;
	logic [15:0]       a_q;
	logic [15:0]       b_q;
	logic [15:0]       cur_q;
	logic [15:0]       hi_q;
	logic              done_q;
	result_t           res_q;

	logic              ld_horiz;
	logic [15:0]       ld_fix;
	logic [15:0]       ld_a;
	logic [15:0]       ld_b;
	logic              row_hit;

	logic [15:0]       lim;
	logic [15:0]       lim_last;
	logic              skip;
	logic [15:0]       lo_c;
	logic [15:0]       hi_c;
	logic              fin_line;

	logic [15:0]       lx;
	logic [15:0]       ly;
	logic [AFW-1:0]    loc_full;
	logic              loc_ok;
	logic [ADDR_W-1:0] loc_addr;
	logic [7:0]        loc_mask;

	pix_op_t           op_req;
	store_stat_t       st_stat;

	mfde_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (op_req),
		.stat   (st_stat)
	);

	always_comb begin
		ld_horiz = 1'b1;
		ld_fix   = cmd_q.y;
		ld_a     = cmd_q.x;
		ld_b     = xr_q;
		if (state_q == ST_ROW) begin
			ld_fix = 16'(row_q);
		end else if (cmd_q.func == FN_HLINE) begin
			ld_b = cmd_q.x_end;
		end else if (cmd_q.func == FN_VLINE) begin
			ld_horiz = 1'b0;
			ld_fix   = cmd_q.x;
			ld_a     = cmd_q.y;
			ld_b     = cmd_q.y_end;
		end else begin
			case (seg_q)
				2'd1: ld_fix = yb_q;
				2'd2: begin
					ld_horiz = 1'b0;
					ld_fix   = cmd_q.x;
					ld_a     = cmd_q.y;
					ld_b     = yb_q;
				end
				2'd3: begin
					ld_horiz = 1'b0;
					ld_fix   = xr_q;
					ld_a     = cmd_q.y;
					ld_b     = yb_q;
				end
				default: ;
			endcase
		end
		row_hit = (16'(row_q) - cmd_q.y) < cmd_q.rect_height;
	end

	always_comb begin
		lim      = horiz_q ? H_LIM : W_LIM;
		lim_last = horiz_q ? X_LAST : Y_LAST;
		skip     = fix_q >= lim;
		lo_c     = (a_q < b_q) ? a_q : b_q;
		hi_c     = (a_q < b_q) ? b_q : a_q;
		if (lo_c > lim_last) begin
			lo_c = lim_last;
		end
		if (hi_c > lim_last) begin
			hi_c = lim_last;
		end
		fin_line = (state_q == ST_LINIT && skip) ||
		           (state_q == ST_WALK && cur_q == hi_q) ||
		           (state_q == ST_ROW && !row_hit);
	end

	always_comb begin
		lx = cmd.x;
		ly = cmd.y;
		if (state_q != ST_IDLE) begin
			lx = horiz_q ? cur_q : fix_q;
			ly = horiz_q ? fix_q : cur_q;
		end
		loc_full = AFW'(ly[YW-1:0]) * AFW'(BYTES_PER_ROW) + AFW'(lx[15:3]);
		loc_ok   = lx < W_LIM && ly < H_LIM && loc_full < AFW'(STORE_DEPTH);
		loc_addr = loc_full[ADDR_W-1:0];
		loc_mask = TOP_BIT >> lx[2:0];
	end

	always_comb begin
		op_req = '0;
		case (state_q)
			ST_IDLE: begin
				op_req.vld  = start && loc_ok && (cmd.func inside {FN_SET, FN_GET});
				op_req.kind = (cmd.func == FN_GET) ? OP_READ : (cmd.color ? OP_SET : OP_CLR);
				op_req.addr = loc_addr;
				op_req.mask = loc_mask;
			end
			ST_WALK: begin
				op_req.vld  = loc_ok;
				op_req.kind = cmd_q.color ? OP_SET : OP_CLR;
				op_req.addr = loc_addr;
				op_req.mask = loc_mask;
			end
			ST_INV: begin
				op_req.vld  = 1'b1;
				op_req.kind = OP_XOR;
				op_req.addr = inv_q;
				op_req.mask = FULL_MASK;
			end
			ST_CLEAR: begin
				op_req.vld  = 1'b1;
				op_req.kind = OP_CLR;
				op_req.addr = clr_q;
				op_req.mask = FULL_MASK;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + ADDR_W'(1);
					if (clr_q == CLR_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						cmd_q   <= cmd;
						xr_q    <= cmd.x + cmd.rect_width - 16'd1;
						yb_q    <= cmd.y + cmd.rect_height - 16'd1;
						seg_q   <= '0;
						row_q   <= '0;
						inv_q   <= '0;
						inv_n_q <= (cmd.byte_count > BUF_N) ? BUF_N : cmd.byte_count;
						case (cmd.func)
							FN_HLINE, FN_VLINE: state_q <= ST_SEG;
							FN_RECT:            state_q <= cmd.filled ? ST_ROW : ST_SEG;
							FN_INV:  state_q <= (cmd.byte_count == '0) ? ST_FIN : ST_INV;
							default:            state_q <= ST_FIN;
						endcase
					end
				end
				ST_SEG: begin
					horiz_q <= ld_horiz;
					fix_q   <= ld_fix;
					a_q     <= ld_a;
					b_q     <= ld_b;
					state_q <= ST_LINIT;
				end
				ST_ROW: begin
					if (row_hit) begin
						horiz_q <= ld_horiz;
						fix_q   <= ld_fix;
						a_q     <= ld_a;
						b_q     <= ld_b;
						state_q <= ST_LINIT;
					end
				end
				ST_LINIT: begin
					if (!skip) begin
						cur_q   <= lo_c;
						hi_q    <= hi_c;
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (cur_q != hi_q) begin
						cur_q <= cur_q + 16'd1;
					end
				end
				ST_INV: begin
					inv_q <= inv_q + ADDR_W'(1);
					if ({1'b0, inv_q} + (ADDR_W + 1)'(1) == inv_n_q) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					done_q          <= 1'b1;
					res_q.pixel     <= st_stat.rd_pix;
					res_q.done_func <= cmd_q.func;
					state_q         <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			// advance to the next row or outline edge once a line is finished, or finish the item after the last
			if (fin_line) begin
				if (cmd_q.func == FN_RECT && cmd_q.filled) begin
					if (row_q == ROW_LAST) begin
						state_q <= ST_FIN;
					end else begin
						row_q   <= row_q + YW'(1);
						state_q <= ST_ROW;
					end
				end else if (cmd_q.func == FN_RECT && seg_q != 2'd3) begin
					seg_q   <= seg_q + 2'd1;
					state_q <= ST_SEG;
				end else begin
					state_q <= ST_FIN;
				end
			end
		end
	end

	assign busy   = state_q != ST_IDLE;
	assign done   = done_q;
	assign result = res_q;

`ifndef ASSERT_OFF
	a_done_after_fin: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_FIN))
		else $error("done without a finishing cycle");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

	a_drained: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !st_stat.pend)
		else $error("item reported while a store write is pending");

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && !start) |-> !op_req.vld)
		else $error("store access issued while idle");
`endif

endmodule

>>> tb/draw_checker.sv
`timescale 1ns / 100ps

module draw_checker import mfde_pkg::*; #(
	parameter int WIDTH         = DEF_WIDTH,
	parameter int HEIGHT        = DEF_HEIGHT,
	parameter int BYTES_PER_ROW = DEF_BYTES_PER_ROW
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  logic    busy,
	input  cmd_t    cmd,
	input  logic    done,
	input  result_t result,
	output int      errors,
	output int      pending
);

	logic [7:0]  frame [STORE_DEPTH];
	result_t     answer_q[$];
	int unsigned n_results;

	function automatic bit locate(input int unsigned x, input int unsigned y,
			output int unsigned addr, output logic [7:0] mask);
		if (x >= WIDTH || y >= HEIGHT)
			return 0;
		addr = y * BYTES_PER_ROW + x / 8;
		if (addr >= STORE_DEPTH)
			return 0;
		mask = TOP_BIT >> (x % 8);
		return 1;
	endfunction

	function automatic void plot(input int unsigned x, input int unsigned y, input logic black);
		int unsigned addr;
		logic [7:0]  mask;
		if (!locate(x, y, addr, mask))
			return;
		frame[addr] = black ? (frame[addr] | mask) : (frame[addr] & ~mask);
	endfunction

	function automatic logic peek(input int unsigned x, input int unsigned y);
		int unsigned addr;
		logic [7:0]  mask;
		if (!locate(x, y, addr, mask))
			return 1'b0;
		return |(frame[addr] & mask);
	endfunction

	function automatic void span_h(input int unsigned a, input int unsigned b,
			input int unsigned y, input logic black);
		int unsigned lo, hi, x;
		if (y >= HEIGHT)
			return;
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		if (lo >= WIDTH) lo = WIDTH - 1;
		if (hi >= WIDTH) hi = WIDTH - 1;
		for (x = lo; x <= hi; x++)
			plot(x, y, black);
	endfunction

	function automatic void span_v(input int unsigned x, input int unsigned a,
			input int unsigned b, input logic black);
		int unsigned lo, hi, y;
		if (x >= WIDTH)
			return;
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		if (lo >= HEIGHT) lo = HEIGHT - 1;
		if (hi >= HEIGHT) hi = HEIGHT - 1;
		for (y = lo; y <= hi; y++)
			plot(x, y, black);
	endfunction

	function automatic void box(input cmd_t c);
		logic [15:0] right, bottom, offs;
		int unsigned row;
		right  = c.x + c.rect_width - 16'd1;
		bottom = c.y + c.rect_height - 16'd1;
		if (c.filled) begin
			for (row = 0; row < HEIGHT; row++) begin
				offs = 16'(row - 32'(c.y));
				if (offs < c.rect_height)
					span_h(32'(c.x), 32'(right), row, c.color);
			end
		end else begin
			span_h(32'(c.x), 32'(right), 32'(c.y), c.color);
			span_h(32'(c.x), 32'(right), 32'(bottom), c.color);
			span_v(32'(c.x), 32'(c.y), 32'(bottom), c.color);
			span_v(32'(right), 32'(c.y), 32'(bottom), c.color);
		end
	endfunction

	function automatic void flip(input int unsigned count);
		int unsigned limit, i;
		limit = HEIGHT * BYTES_PER_ROW;
		if (limit > STORE_DEPTH) limit = STORE_DEPTH;
		if (count > limit) count = limit;
		for (i = 0; i < count; i++)
			frame[i] = ~frame[i];
	endfunction

	function automatic result_t apply_cmd(input cmd_t c);
		result_t r;
		r.pixel     = 1'b0;
		r.done_func = c.func;
		case (c.func)
			FN_SET:   plot(32'(c.x), 32'(c.y), c.color);
			FN_GET:   r.pixel = peek(32'(c.x), 32'(c.y));
			FN_HLINE: span_h(32'(c.x), 32'(c.x_end), 32'(c.y), c.color);
			FN_VLINE: span_v(32'(c.x), 32'(c.y), 32'(c.y_end), c.color);
			FN_RECT:  box(c);
			FN_INV:   flip(32'(c.byte_count));
			default:  ;
		endcase
		return r;
	endfunction

	task automatic report(input string what);
		if (errors < 100)
			$display("mismatch: %s", what);
		errors++;
	endtask

	always @(posedge clk) begin
		result_t want;
		int      i;
		if (!arst_n) begin
			answer_q.delete();
			for (i = 0; i < STORE_DEPTH; i++)
				frame[i] = 8'h00;
			n_results = 0;
		end else begin
			if (done) begin
				if (answer_q.size() == 0) begin
					report($sformatf("result %0d with no item pending (func %0d pixel %b)",
						n_results, result.done_func, result.pixel));
				end else begin
					want = answer_q.pop_front();
					if (result.pixel !== want.pixel)
						report($sformatf("result %0d pixel got %b want %b",
							n_results, result.pixel, want.pixel));
					if (result.done_func !== want.done_func)
						report($sformatf("result %0d done_func got %0d want %0d",
							n_results, result.done_func, want.done_func));
				end
				n_results++;
			end
			if (start && !busy)
				answer_q.push_back(apply_cmd(cmd));
		end
		pending = answer_q.size();
	end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import mfde_pkg::*;

	logic    clk    = 1'b0;
	logic    arst_n = 1'b0;
	logic    start  = 1'b0;
	cmd_t    cmd    = '0;
	logic    busy;
	logic    done;
	result_t result;
	int      errors;
	int      pending;
	bit      burst  = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	mono_framebuffer_draw_engine u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.result (result)
	);

	draw_checker u_chk (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.cmd     (cmd),
		.done    (done),
		.result  (result),
		.errors  (errors),
		.pending (pending)
	);

	initial begin
		#40_000_000;
		$display("== FAIL ==");
		$finish;
	end

	function automatic cmd_t make_cmd(input logic [2:0] func, input logic [15:0] x,
			input logic [15:0] y, input logic [15:0] x_end, input logic [15:0] y_end,
			input logic [15:0] w, input logic [15:0] h, input logic color,
			input logic filled, input logic [12:0] count);
		cmd_t c;
		c.func        = func;
		c.x           = x;
		c.y           = y;
		c.x_end       = x_end;
		c.y_end       = y_end;
		c.rect_width  = w;
		c.rect_height = h;
		c.color       = color;
		c.filled      = filled;
		c.byte_count  = count;
		return c;
	endfunction

	function automatic cmd_t random_cmd();
		cmd_t        c;
		int unsigned pick;
		c.x           = 16'($urandom);
		c.y           = 16'($urandom);
		c.x_end       = 16'($urandom);
		c.y_end       = 16'($urandom);
		c.rect_width  = 16'($urandom);
		c.rect_height = 16'($urandom);
		c.color       = 1'($urandom);
		c.filled      = 1'($urandom);
		c.byte_count  = 13'($urandom);
		pick = $urandom_range(0, 99);
		c.func = (pick < 22) ? FN_SET :
			(pick < 44) ? FN_GET :
			(pick < 56) ? FN_HLINE :
			(pick < 68) ? FN_VLINE :
			(pick < 86) ? FN_RECT :
			(pick < 96) ? FN_INV : FN_INV + 3'($urandom_range(1, 2));
		if ($urandom_range(0, 7) != 0) begin
			if ($urandom_range(0, 1) == 0) begin
				c.x = 16'($urandom_range(0, 31));
				c.y = 16'($urandom_range(0, 15));
			end else begin
				c.x = 16'($urandom_range(0, DEF_WIDTH + 7));
				c.y = 16'($urandom_range(0, DEF_HEIGHT + 3));
			end
			c.x_end = 16'($urandom_range(0, DEF_WIDTH + 7));
			c.y_end = 16'($urandom_range(0, DEF_HEIGHT + 3));
		end
		case (c.func)
			FN_RECT: begin
				pick = $urandom_range(0, 31);
				if (pick == 1) begin
					c.rect_width  = 16'($urandom_range(0, DEF_WIDTH + 8));
					c.rect_height = 16'($urandom_range(0, DEF_HEIGHT + 4));
				end else if (pick != 0) begin
					c.rect_width  = 16'($urandom_range(0, 20));
					c.rect_height = 16'($urandom_range(0, 20));
				end
			end
			FN_INV: begin
				if ($urandom_range(0, 15) != 0)
					c.byte_count = 13'($urandom_range(0, 64));
			end
			default: ;
		endcase
		return c;
	endfunction

	task automatic issue(input cmd_t c);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd   = c;
		start = 1'b1;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		@(negedge clk);
	endtask

	initial begin
		int i;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		issue(make_cmd(FN_GET,   0,     0,     0,     0,   0,   0,   0, 0, 0));
		issue(make_cmd(FN_SET,   0,     0,     0,     0,   0,   0,   1, 0, 0));
		issue(make_cmd(FN_GET,   0,     0,     0,     0,   0,   0,   0, 0, 0));
		issue(make_cmd(FN_SET,   255,   127,   0,     0,   0,   0,   1, 0, 0));
		issue(make_cmd(FN_GET,   255,   127,   0,     0,   0,   0,   0, 0, 0));
		issue(make_cmd(FN_SET,   256,   0,     0,     0,   0,   0,   1, 0, 0));
		issue(make_cmd(FN_SET,   0,     128,   0,     0,   0,   0,   1, 0, 0));
		issue(make_cmd(FN_GET,   65535, 65535, 0,     0,   0,   0,   0, 0, 0));
		issue(make_cmd(FN_SET,   0,     0,     0,     0,   0,   0,   0, 0, 0));
		issue(make_cmd(FN_GET,   0,     0,     0,     0,   0,   0,   0, 0, 0));
		issue(make_cmd(FN_HLINE, 10,    5,     0,     0,   0,   0,   1, 0, 0));
		issue(make_cmd(FN_GET,   3,     5,     0,     0,   0,   0,   0, 0, 0));
		issue(make_cmd(FN_HLINE, 300,   6,     65535, 0,   0,   0,   1, 0, 0));
		issue(make_cmd(FN_GET,   255,   6,     0,     0,   0,   0,   0, 0, 0));
		issue(make_cmd(FN_HLINE, 0,     128,   255,   0,   0,   0,   1, 0, 0));
		issue(make_cmd(FN_VLINE, 20,    200,   0,     3,   0,   0,   1, 0, 0));
		issue(make_cmd(FN_GET,   20,    127,   0,     0,   0,   0,   0, 0, 0));
		issue(make_cmd(FN_VLINE, 256,   0,     0,     127, 0,   0,   1, 0, 0));
		issue(make_cmd(FN_RECT,  0,     0,     0,     0,   256, 128, 1, 1, 0));
		issue(make_cmd(FN_GET,   100,   100,   0,     0,   0,   0,   0, 0, 0));
		issue(make_cmd(FN_RECT,  10,    10,    0,     0,   0,   0,   0, 0, 0));
		issue(make_cmd(FN_RECT,  100,   50,    0,     0,   0,   0,   0, 1, 0));
		issue(make_cmd(FN_RECT,  65500, 65530, 0,     0,   100, 10,  0, 1, 0));
		issue(make_cmd(FN_RECT,  65530, 120,   0,     0,   20,  20,  0, 0, 0));
		issue(make_cmd(FN_INV,   0,     0,     0,     0,   0,   0,   0, 0, 0));
		issue(make_cmd(FN_INV,   0,     0,     0,     0,   0,   0,   0, 0, 1));
		issue(make_cmd(FN_INV,   0,     0,     0,     0,   0,   0,   0, 0, 4096));
		issue(make_cmd(FN_INV,   0,     0,     0,     0,   0,   0,   0, 0, 8191));
		issue(make_cmd(FN_GET,   7,     0,     0,     0,   0,   0,   0, 0, 0));
		issue(make_cmd(FN_INV + 3'd1, 0, 0,    0,     0,   0,   0,   0, 0, 0));
		issue(make_cmd(FN_INV + 3'd2, 0, 0,    0,     0,   0,   0,   1, 1, 0));

		for (i = 0; i < 1650; i++) begin
			if (i % 64 == 0)
				burst = ($urandom_range(0, 3) == 0);
			issue(random_cmd());
		end
		start = 1'b0;

		while (pending != 0)
			@(negedge clk);
		repeat (40) @(negedge clk);

		if (errors == 0 && pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
